@@ rtl/cusr_pkg.sv @@
// shared types and constants for the cartridge unlock and control register block
`default_nettype none

package cusr_pkg;

   localparam int ADDR_W       = 25;
   localparam int DATA_W       = 16;
   localparam int SEL_W        = 4;
   localparam int SEL_CODES    = 16;
   localparam int DECODE_COUNT = 12;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] data_type;
   typedef logic [SEL_W-1:0]  sel_type;

   // key values
   localparam data_type KEY_A = 16'hd200;
   localparam data_type KEY_B = 16'h1500;

   // key and relock addresses, offsets from the cartridge base
   localparam addr_type ADDR_KEY1   = 25'h1fe0000;
   localparam addr_type ADDR_KEY2   = 25'h0000000;
   localparam addr_type ADDR_KEY3   = 25'h0020000;
   localparam addr_type ADDR_KEY4   = 25'h0040000;
   localparam addr_type ADDR_RELOCK = 25'h1fc0000;

   // write-protect commands
   localparam data_type WP_NOR_OPEN  = 16'h1500;
   localparam data_type WP_NOR_CLOSE = 16'hd200;
   localparam data_type WP_RAM_OPEN  = 16'ha500;
   localparam data_type WP_RAM_CLOSE = 16'ha200;

   // select codes
   localparam sel_type SEL_NONE  = 4'd0;
   localparam sel_type SEL_ROM   = 4'd1;
   localparam sel_type SEL_PSRAM = 4'd2;
   localparam sel_type SEL_RAM   = 4'd3;
   localparam sel_type SEL_WP    = 4'd4;
   localparam sel_type SEL_SD    = 4'd5;
   localparam sel_type SEL_BUF   = 4'd6;
   localparam sel_type SEL_SPIC  = 4'd7;

   // decoded register addresses, entry i belongs to select code i+1
   localparam addr_type DECODE_ADDR [DECODE_COUNT] = '{
      25'h1880000, 25'h1860000, 25'h1c00000, 25'h1c40000,
      25'h1400000, 25'h1420000, 25'h1660000, 25'h1680000,
      25'h16a0000, 25'h16c0000, 25'h1a40000, 25'h1e20000
   };

   typedef enum logic [2:0] {
      KEY_IDLE,
      KEY_FIRST,
      KEY_SECOND,
      KEY_THIRD,
      KEY_OPEN
   } key_state_type;

   typedef struct packed {
      logic is_open;
      logic relock_hit;
   } key_status_type;

   typedef struct packed {
      logic     updated;
      sel_type  select;
      data_type value;
   } latch_type;

   typedef struct packed {
      data_type rom_page;
      data_type ram_page;
      data_type psram_page;
      data_type sd_control;
      data_type buffer_control;
      data_type spi_control;
      logic     nor_write_open;
      logic     ram_write_open;
   } cart_view_type;

endpackage

`default_nettype wire

@@ rtl/cart_unlock_sequence_registers.sv @@
// top level of the cartridge unlock sequence and control register block
`default_nettype none

// Each item on the req_ channel is one halfword write to the cartridge bus:
// its byte address minus the cartridge base, and the value. Every write gives
// exactly one rsp_ item. Four key writes in a row (0xd200 at 0x1fe0000,
// 0x1500 at 0x0000000, 0xd200 at 0x0020000, 0x1500 at 0x0040000) unlock the
// block; a wrong write drops back to idle, or to step one if it is the first
// key. While unlocked, a write to one of the decoded addresses latches the
// value into that control register and the response reports it through
// rsp_reg_updated, rsp_reg_select and rsp_reg_value; 0x1500 written to
// 0x1fc0000 locks again. The remaining rsp_ fields show the register
// contents and enable flags as they stand after that write. The input
// register loads at the accepting edge, the result register when the item
// moves on, which a full and stalled result register holds off; one item
// is taken every cycle when rsp_stall is low; the decode and key compare
// sit in one stage between the two registers.
module cart_unlock_sequence_registers #(
   parameter int NUM_REGS = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // write channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire cusr_pkg::addr_type  req_bus_address,
   input  wire cusr_pkg::data_type  req_write_data,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_reg_updated,
   output cusr_pkg::sel_type        rsp_reg_select,
   output cusr_pkg::data_type       rsp_reg_value,
   output logic                     rsp_unlocked,
   output cusr_pkg::data_type       rsp_rom_page,
   output cusr_pkg::data_type       rsp_ram_page,
   output cusr_pkg::data_type       rsp_psram_page,
   output logic                     rsp_nor_write_open,
   output logic                     rsp_ram_write_open,
   output cusr_pkg::data_type       rsp_sd_control,
   output cusr_pkg::data_type       rsp_buffer_control,
   output cusr_pkg::data_type       rsp_spi_control
);
   import cusr_pkg::*;

   // input register
   logic           in_valid_ff;
   logic           in_valid_in;
   addr_type       in_addr_ff;
   data_type       in_data_ff;

   // result register
   logic           out_valid_ff;
   logic           out_valid_in;
   latch_type      out_latch_ff;

   logic           advance;
   logic           req_take;
   key_status_type key_status;
   latch_type      latch;
   cart_view_type  view;

   // item moves into the result register when that register is free or drains
   assign advance  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_addr_ff <= req_bus_address;
         in_data_ff <= req_write_data;
      end
      if (advance) begin
         out_latch_ff <= latch;
      end
   end

   // state only moves when an item enters the result register
   cusr_key_fsm u_key_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .bus_address (in_addr_ff),
      .write_data  (in_data_ff),
      .status      (key_status)
   );

   cusr_reg_file #(
      .NUM_REGS (NUM_REGS)
   ) u_reg_file (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .bus_address (in_addr_ff),
      .write_data  (in_data_ff),
      .status      (key_status),
      .latch       (latch),
      .view        (view)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_reg_updated = out_latch_ff.updated;
   assign rsp_reg_select  = out_latch_ff.select;
   assign rsp_reg_value   = out_latch_ff.value;

   // state changes only together with the result register, so the live
   // state always matches the item on display
   assign rsp_unlocked       = key_status.is_open;
   assign rsp_rom_page       = view.rom_page;
   assign rsp_ram_page       = view.ram_page;
   assign rsp_psram_page     = view.psram_page;
   assign rsp_nor_write_open = view.nor_write_open;
   assign rsp_ram_write_open = view.ram_write_open;
   assign rsp_sd_control     = view.sd_control;
   assign rsp_buffer_control = view.buffer_control;
   assign rsp_spi_control    = view.spi_control;

endmodule

`default_nettype wire

@@ rtl/cusr_key_fsm.sv @@
// key sequence tracker: unlock after four key writes, relock on command
`default_nettype none

module cusr_key_fsm (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire cusr_pkg::addr_type      bus_address,
   input  wire cusr_pkg::data_type      write_data,
   output cusr_pkg::key_status_type     status
);
   import cusr_pkg::*;

   key_state_type state_ff;
   key_state_type state_in;
   logic          first_key;
   logic          restart;

   assign first_key = (bus_address == ADDR_KEY1) && (write_data == KEY_A);

   // wrong write falls back, or restarts when it is itself the first key
   always_comb begin
      restart = first_key;
   end

   always_comb begin
      state_in = state_ff;
      if (step) begin
         unique case (state_ff)
            KEY_OPEN: begin
               if (status.relock_hit) begin
                  state_in = KEY_IDLE;
               end
            end
            KEY_FIRST: begin
               if (bus_address == ADDR_KEY2 && write_data == KEY_B) begin
                  state_in = KEY_SECOND;
               end else begin
                  state_in = restart ? KEY_FIRST : KEY_IDLE;
               end
            end
            KEY_SECOND: begin
               if (bus_address == ADDR_KEY3 && write_data == KEY_A) begin
                  state_in = KEY_THIRD;
               end else begin
                  state_in = restart ? KEY_FIRST : KEY_IDLE;
               end
            end
            KEY_THIRD: begin
               if (bus_address == ADDR_KEY4 && write_data == KEY_B) begin
                  state_in = KEY_OPEN;
               end else begin
                  state_in = restart ? KEY_FIRST : KEY_IDLE;
               end
            end
            default: begin
               state_in = restart ? KEY_FIRST : KEY_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      status.is_open    = (state_ff == KEY_OPEN);
      status.relock_hit = (bus_address == ADDR_RELOCK) && (write_data == KEY_B);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KEY_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/cusr_reg_file.sv @@
// address decode, control registers and write-protect flags
`default_nettype none

module cusr_reg_file #(
   parameter int NUM_REGS = 12
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire cusr_pkg::addr_type      bus_address,
   input  wire cusr_pkg::data_type      write_data,
   input  wire cusr_pkg::key_status_type status,
   output cusr_pkg::latch_type          latch,
   output cusr_pkg::cart_view_type      view
);
   import cusr_pkg::*;

   data_type regs_ff [NUM_REGS];
   data_type by_code [SEL_CODES];
   sel_type  sel_code;
   logic     nor_flag_ff;
   logic     nor_flag_in;
   logic     ram_flag_ff;
   logic     ram_flag_in;

   // only codes 1..NUM_REGS, and at most 1..DECODE_COUNT, decode
   always_comb begin
      sel_code = SEL_NONE;
      for (int i = 0; i < DECODE_COUNT; i++) begin
         if (i < NUM_REGS && bus_address == DECODE_ADDR[i]) begin
            sel_code = SEL_W'(i + 1);
         end
      end
   end

   always_comb begin
      latch.updated = step && status.is_open && !status.relock_hit
                      && (sel_code != SEL_NONE);
      latch.select  = latch.updated ? sel_code : SEL_NONE;
      latch.value   = latch.updated ? write_data : '0;
   end

   always_comb begin
      nor_flag_in = nor_flag_ff;
      ram_flag_in = ram_flag_ff;
      if (latch.updated && sel_code == SEL_WP) begin
         priority if (write_data == WP_NOR_OPEN) begin
            nor_flag_in = 1'b1;
         end else if (write_data == WP_NOR_CLOSE) begin
            nor_flag_in = 1'b0;
         end else if (write_data == WP_RAM_OPEN) begin
            ram_flag_in = 1'b1;
         end else if (write_data == WP_RAM_CLOSE) begin
            ram_flag_in = 1'b0;
         end else begin
            nor_flag_in = nor_flag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nor_flag_ff <= 1'b0;
         ram_flag_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         nor_flag_ff <= nor_flag_in;
         ram_flag_ff <= ram_flag_in;
         for (int i = 0; i < NUM_REGS; i++) begin
            if (latch.updated && sel_code == SEL_W'(i + 1)) begin
               regs_ff[i] <= write_data;
            end
         end
      end
   end

   // view by select code, missing registers read as zero
   for (genvar g = 0; g < SEL_CODES; g++) begin : g_code
      if (g >= 1 && g <= NUM_REGS) begin : g_present
         assign by_code[g] = regs_ff[g-1];
      end else begin : g_absent
         assign by_code[g] = '0;
      end
   end

   always_comb begin
      view.rom_page       = by_code[SEL_ROM];
      view.ram_page       = by_code[SEL_RAM];
      view.psram_page     = by_code[SEL_PSRAM];
      view.sd_control     = by_code[SEL_SD];
      view.buffer_control = by_code[SEL_BUF];
      view.spi_control    = by_code[SEL_SPIC];
      view.nor_write_open = nor_flag_ff;
      view.ram_write_open = ram_flag_ff;
   end

endmodule

`default_nettype wire
